// File: src/wirs_pkg.sv
// Shared types and constants for the weighted isotonic regression stack.
// No dependencies.
`default_nettype none
package wirs_pkg;
    localparam int VALUE_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int WSUM_W   = 22;
    localparam int IDX_W    = 6;
    localparam int NUM_W    = 55;   // |value*weight| sum fits 32+22+1 bits
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [WSUM_W-1:0]         t_wsum;
    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic [WSUM_W-1:0]       den;
    } t_div_req;
endpackage
`default_nettype wire

// File: src/wirs_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wirs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/wirs_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on wirs_pkg.
`default_nettype none
module wirs_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wirs_pkg::t_div_req i_req,
    output logic                   o_done,
    output wirs_pkg::t_value       o_quot
);
    import wirs_pkg::*;
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NUM_W-1:0]  r_q, n_q;
    logic [WSUM_W:0]   r_rem, n_rem;
    logic [WSUM_W-1:0] r_den, n_den;
    logic              r_neg, n_neg;
    logic              r_done, n_done;
    logic [WSUM_W:0]   w_trial;
    logic [NUM_W-1:0]  w_mag;
    logic [NUM_W-1:0]  w_sq;

    assign w_trial = {r_rem[WSUM_W-1:0], r_q[NUM_W-1]};
    assign w_mag   = i_req.num[NUM_W-1] ? NUM_W'(-i_req.num) : NUM_W'(i_req.num);

    always_comb begin
        n_busy = r_busy; n_cnt = r_cnt; n_q = r_q; n_rem = r_rem;
        n_den = r_den; n_neg = r_neg; n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1; n_cnt = CNT_W'(NUM_W); n_q = w_mag;
            n_rem = '0; n_den = i_req.den; n_neg = i_req.num[NUM_W-1];
        end else if (r_busy) begin
            // shift one dividend bit in, subtract when it fits
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den; r_neg <= n_neg;
    end

    assign w_sq   = r_neg ? (~r_q + 1'b1) : r_q;
    assign o_quot = w_sq[VALUE_W-1:0];
    assign o_done = r_done;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy)
        else $error("divider done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_req.start |=> r_cnt == $past(r_cnt) - 1'b1 || r_done)
        else $error("divider count skipped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !r_busy |-> !$rose(r_done) || $past(r_busy))
        else $error("divider done without work");
endmodule
`default_nettype wire

// File: src/weighted_isotonic_regression_stack_top.sv
// Top level of the weighted isotonic regression stack (pool adjacent violators).
// Depends on wirs_pkg, wirs_ram and wirs_div.
`default_nettype none
// Samples arrive one transaction at a time and are pushed as blocks on a stack
// held in one synchronous RAM (mean, weight sum, last point index per entry).
// After each push the top two blocks are read in turn over the one RAM port and
// merged while the upper mean lies strictly below the lower one; each merge runs
// a bit-serial division of the weighted sum by the weight sum. A transaction
// with tlast, or the one that fills MAX_POINTS, closes the set: the fitted
// values are then streamed out in input order, one per cycle while the sink is
// ready, with a RAM read before each block, and the final one flagged in tlast. New
// samples are held off while merging or emitting. A zero weight counts as one.
module weighted_isotonic_regression_stack_top #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // sample_value[31:0], sample_weight[47:32]
    input  wire logic        s_axis_tlast,  // end_of_set
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // fitted_value[31:0], point_index[37:32], zero
    output logic             m_axis_tlast   // final_point
);
    import wirs_pkg::*;
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = AW + 1;
    localparam int EW  = 7;
    localparam int RW  = VALUE_W + WSUM_W + EW;

    localparam logic [2:0] ST_IDLE = 3'd0, ST_RDT = 3'd1, ST_RDB = 3'd2,
                           ST_CMP = 3'd3, ST_DIV = 3'd4, ST_ORD = 3'd5,
                           ST_OLD = 3'd6, ST_OUT = 3'd7;

    logic [2:0]    r_st, n_st;
    logic [CW-1:0] r_depth, n_depth, r_seen, n_seen;
    logic          r_close, n_close;
    logic [AW-1:0] r_blk, n_blk;          // emit block pointer
    logic [EW-1:0] r_pt, n_pt, r_end, n_end;
    t_value        r_mt, n_mt, r_omean, n_omean;
    t_wsum         r_wt, n_wt, r_wb, n_wb;
    logic [EW-1:0] r_et, n_et;
    t_div_req      w_req;
    logic          w_done;
    t_value        w_quot;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [RW-1:0] w_wdata, w_rdata;
    t_value        w_rmean;
    t_wsum         w_rw;
    logic [EW-1:0] w_re;
    logic [WEIGHT_W-1:0] w_win;
    logic          w_acc, w_full;
    logic          r_ov, n_ov;
    logic [VALUE_W-1:0] r_od, n_od;
    logic [IDX_W-1:0]   r_oi, n_oi;
    logic          r_ol, n_ol;

    assign {w_rmean, w_rw, w_re} = w_rdata;
    assign w_win  = s_axis_tdata[47:32];
    assign s_axis_tready = (r_st == ST_IDLE);
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_full = (r_seen + 1'b1) == CW'(MAX_POINTS);

    wirs_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_stack (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata));

    wirs_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
        .o_done(w_done), .o_quot(w_quot));

    always_comb begin
        n_st = r_st; n_depth = r_depth; n_seen = r_seen; n_close = r_close;
        n_blk = r_blk; n_pt = r_pt; n_end = r_end; n_mt = r_mt; n_omean = r_omean;
        n_wt = r_wt; n_wb = r_wb; n_et = r_et;
        n_ov = r_ov; n_od = r_od; n_oi = r_oi; n_ol = r_ol;
        w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_raddr = '0;
        w_req = '{start: 1'b0, num: '0, den: '0};
        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end
        case (r_st)
            ST_IDLE: begin
                if (w_acc) begin
                    // push the sample as a new block
                    w_we    = 1'b1;
                    w_waddr = r_depth[AW-1:0];
                    w_wdata = {s_axis_tdata[31:0],
                               WSUM_W'((w_win == '0) ? WEIGHT_W'(1) : w_win),
                               EW'(r_seen)};
                    n_depth = r_depth + 1'b1;
                    n_seen  = r_seen + 1'b1;
                    n_close = s_axis_tlast || w_full;
                    n_st    = ST_RDT;
                end
            end
            ST_RDT: begin
                if (r_depth > CW'(1)) begin
                    w_raddr = AW'(r_depth - CW'(1));
                    n_st = ST_RDB;
                end else begin
                    n_st = r_close ? ST_ORD : ST_IDLE;
                    n_blk = '0; n_pt = '0;
                end
            end
            ST_RDB: begin
                w_raddr = AW'(r_depth - CW'(2));
                n_mt = w_rmean; n_wt = w_rw; n_et = w_re;
                n_st = ST_CMP;
            end
            ST_CMP: begin
                if (r_mt < w_rmean) begin
                    n_wb = w_rw;
                    w_req.start = 1'b1;
                    w_req.num = NUM_W'(r_mt * $signed({1'b0, r_wt}))
                              + NUM_W'(w_rmean * $signed({1'b0, w_rw}));
                    w_req.den = r_wt + w_rw;
                    n_st = ST_DIV;
                end else begin
                    n_st = r_close ? ST_ORD : ST_IDLE;
                    n_blk = '0; n_pt = '0;
                end
            end
            ST_DIV: begin
                if (w_done) begin
                    // fold the top block into the one beneath
                    w_we    = 1'b1;
                    w_waddr = AW'(r_depth - CW'(2));
                    w_wdata = {w_quot, WSUM_W'(r_wt + r_wb), r_et};
                    n_depth = r_depth - 1'b1;
                    n_st    = ST_RDT;
                end
            end
            ST_ORD: begin
                w_raddr = r_blk;
                n_st = ST_OLD;
            end
            ST_OLD: begin
                n_omean = w_rmean;
                n_end = (w_re >= EW'(r_seen)) ? EW'(r_seen - 1'b1) : w_re;
                n_st = ST_OUT;
            end
            ST_OUT: begin
                if (!n_ov) begin
                    n_ov = 1'b1; n_od = r_omean; n_oi = IDX_W'(r_pt);
                    n_ol = (r_pt + 1'b1) == EW'(r_seen);
                    n_pt = r_pt + 1'b1;
                    if (n_ol) begin
                        n_st = ST_IDLE; n_depth = '0; n_seen = '0;
                    end else if (r_pt == r_end) begin
                        n_blk = r_blk + 1'b1; n_st = ST_ORD;
                    end
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_depth <= '0; r_seen <= '0; r_ov <= 1'b0;
            r_close <= 1'b0;
        end else begin
            r_st <= n_st; r_depth <= n_depth; r_seen <= n_seen; r_ov <= n_ov;
            r_close <= n_close;
        end
        r_blk <= n_blk; r_pt <= n_pt; r_end <= n_end; r_mt <= n_mt;
        r_omean <= n_omean; r_wt <= n_wt; r_wb <= n_wb; r_et <= n_et;
        r_od <= n_od; r_oi <= n_oi; r_ol <= n_ol;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {2'b00, r_oi, r_od};
    assign m_axis_tlast  = r_ol;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_depth <= r_seen)
        else $error("more blocks than points");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_DIV && w_done |=> r_depth == $past(r_depth) - 1'b1)
        else $error("merge did not pop");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov && $stable(r_od) && $stable(r_oi)
            && $stable(r_ol))
        else $error("output changed while held");
endmodule
`default_nettype wire
